FILE: src/buvm_pkg.sv
// Shared types and constants for the barycentric UV mapper.
// Used by buvm_div and barycentric_uv_mapper_unit; depends on nothing.
package buvm_pkg;

    localparam int COORD_W   = 24;
    localparam int UV_W      = 18;
    localparam int SIZE_W    = 15;
    localparam int TEX_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    // Cross products of 25-bit edges have magnitudes up to 2^49.
    localparam int MAG_W     = 50;
    localparam int REM_W     = MAG_W + 1;
    // Weight quotient: 15 integer bits and 25 fraction bits (one for rounding).
    localparam int INT_BITS  = 15;
    localparam int FRAC_BITS = 25;
    localparam int QUO_W     = INT_BITS + FRAC_BITS;
    localparam int DIV_LAT   = QUO_W + 1;

    localparam logic [MAG_W-1:0] DEGEN_LIMIT = MAG_W'(2073);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRI_A  = 3'd0,
        REG_TRI_B  = 3'd1,
        REG_TRI_C  = 3'd2,
        REG_UV_A   = 3'd3,
        REG_UV_B   = 3'd4,
        REG_UV_C   = 3'd5,
        REG_TEX_W  = 3'd6,
        REG_TEX_H  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } point_t;

    typedef struct packed {
        logic signed [TEX_W-1:0] tex_x;
        logic signed [TEX_W-1:0] tex_y;
        logic                    degenerate;
        logic                    end_of_polygon;
    } result_t;

endpackage

FILE: src/buvm_div.sv
// Pipelined restoring divider: one quotient bit per stage, floor(num * 2^25 / den).
// Flags quotients of 2^15 and above as saturated. Depends on buvm_pkg.
module buvm_div
    import buvm_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [MAG_W-1:0] num,
    input  logic [MAG_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             sat
);

    localparam int SH_W = MAG_W + INT_BITS - 1;

    logic [REM_W-1:0] rem_reg [0:QUO_W];
    logic [MAG_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             sat_reg [0:QUO_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= {INT_BITS'(0), num} >= {den, INT_BITS'(0)};
            rem_reg[0] <= REM_W'(num);
            den_reg[0] <= den;
            quo_reg[0] <= '0;
        end
    end

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_step
        logic             ge;
        logic [REM_W-1:0] rem_next;

        if (s < INT_BITS)
        begin : g_int
            // Integer bits: compare against the divisor shifted into place.
            localparam int J = INT_BITS - 1 - s;
            logic [SH_W-1:0] dsh;
            logic [SH_W-1:0] rx;
            logic [SH_W-1:0] diff;
            assign dsh  = SH_W'(den_reg[s]) << J;
            assign rx   = SH_W'(rem_reg[s]);
            assign diff = rx - dsh;
            assign ge   = rx >= dsh;
            assign rem_next = ge ? diff[REM_W-1:0] : rem_reg[s];
        end
        else
        begin : g_frac
            logic [REM_W-1:0] r2;
            assign r2 = {rem_reg[s][REM_W-2:0], 1'b0};
            assign ge = r2 >= {1'b0, den_reg[s]};
            assign rem_next = ge ? r2 - {1'b0, den_reg[s]} : r2;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                den_reg[s+1] <= den_reg[s];
                quo_reg[s+1] <= {quo_reg[s][QUO_W-2:0], ge};
                sat_reg[s+1] <= sat_reg[s];
            end
        end
    end

    assign quo = quo_reg[QUO_W];
    assign sat = sat_reg[QUO_W];

endmodule

FILE: src/barycentric_uv_mapper_unit.sv
// Top level of the barycentric UV mapper: setup, weight division, interpolation.
// Depends on buvm_pkg and buvm_div.
//
// Usage: points enter on in_valid/in_ready as point_t beats, one result_t beat
// leaves on out_valid/out_ready per point, in order. The triangle, UV triangle
// and texture size are written on cfg_write/cfg_index/cfg_data while no point
// is in flight; unknown indexes are ignored.
// Throughput is one point per cycle while in_ready is high; the two weight
// dividers are pipelined at one quotient bit per stage, which sets most of the
// depth.
// A degenerate triangle (|cross| below 2073 in Q.16) gives zero coordinates
// with the degenerate flag set.
// Reset empties the pipeline and loads the register defaults: all vertices
// zero, texture size 1024 by 1024.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the next one; the pipeline then freezes and in_ready drops
// until the skid register drains. in_ready is the inverse of the skid valid register.
module barycentric_uv_mapper_unit
    import buvm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  point_t                in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SB_LEN = DIV_LAT + 8;

    typedef struct packed {
        logic v;
        logic neg_v;
        logic neg_w;
        logic degen;
        logic last;
    } side_t;

    // Configuration registers.
    logic [47:0]       tri_reg  [3];
    logic [35:0]       uv_reg   [3];
    logic [SIZE_W-1:0] size_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tri_reg[i] <= '0;
                uv_reg[i]  <= '0;
            end
            size_reg[0] <= SIZE_W'(1024);
            size_reg[1] <= SIZE_W'(1024);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TRI_A: tri_reg[0]  <= cfg_data;
                REG_TRI_B: tri_reg[1]  <= cfg_data;
                REG_TRI_C: tri_reg[2]  <= cfg_data;
                REG_UV_A:  uv_reg[0]   <= cfg_data[35:0];
                REG_UV_B:  uv_reg[1]   <= cfg_data[35:0];
                REG_UV_C:  uv_reg[2]   <= cfg_data[35:0];
                REG_TEX_W: size_reg[0] <= cfg_data[SIZE_W-1:0];
                REG_TEX_H: size_reg[1] <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic skid_v_reg;
    logic out_v_reg;
    logic tail_v_reg;
    logic push;

    assign adv      = !skid_v_reg;
    assign in_ready = adv;
    assign push     = adv && tail_v_reg;

    // Stage 1: edge vectors relative to vertex A.
    logic               s1_v_reg, s1_last_reg;
    logic signed [24:0] e0x_reg, e0y_reg, e1x_reg, e1y_reg, e2x_reg, e2y_reg;

    logic [23:0] ax, ay, bx, by, cx, cy;
    assign ax = tri_reg[0][23:0];
    assign ay = tri_reg[0][47:24];
    assign bx = tri_reg[1][23:0];
    assign by = tri_reg[1][47:24];
    assign cx = tri_reg[2][23:0];
    assign cy = tri_reg[2][47:24];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e0x_reg <= {bx[23], bx} - {ax[23], ax};
            e0y_reg <= {by[23], by} - {ay[23], ay};
            e1x_reg <= {cx[23], cx} - {ax[23], ax};
            e1y_reg <= {cy[23], cy} - {ay[23], ay};
            e2x_reg <= {in_data.point_x[23], in_data.point_x} - {ax[23], ax};
            e2y_reg <= {in_data.point_y[23], in_data.point_y} - {ay[23], ay};
            s1_last_reg <= in_data.last_point;
        end
    end

    // Stage 2: the edge products that the three cross products are built from.
    logic               s2_v_reg, s2_last_reg;
    logic signed [49:0] p_reg [6];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= e2x_reg * e1y_reg;
            p_reg[1] <= e2y_reg * e1x_reg;
            p_reg[2] <= e0x_reg * e2y_reg;
            p_reg[3] <= e0y_reg * e2x_reg;
            p_reg[4] <= e0x_reg * e1y_reg;
            p_reg[5] <= e0y_reg * e1x_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: cross products for both weights and the triangle.
    logic        s3_v_reg, s3_last_reg;
    logic [50:0] nv_reg, nw_reg, k_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nv_reg <= {p_reg[0][49], p_reg[0]} - {p_reg[1][49], p_reg[1]};
            nw_reg <= {p_reg[2][49], p_reg[2]} - {p_reg[3][49], p_reg[3]};
            k_reg  <= {p_reg[4][49], p_reg[4]} - {p_reg[5][49], p_reg[5]};
            s3_last_reg <= s2_last_reg;
        end
    end

    // Stage 4: magnitudes, quotient signs and the degeneracy test.
    logic             s4_v_reg;
    logic             s4_last_reg, s4_negv_reg, s4_negw_reg, s4_degen_reg;
    logic [MAG_W-1:0] magv_in_reg, magw_in_reg, magk_reg;
    logic [50:0]      nv_neg, nw_neg, k_neg;
    logic [MAG_W-1:0] magk_next;

    assign nv_neg    = -nv_reg;
    assign nw_neg    = -nw_reg;
    assign k_neg     = -k_reg;
    assign magk_next = k_reg[50] ? k_neg[MAG_W-1:0] : k_reg[MAG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            magv_in_reg  <= nv_reg[50] ? nv_neg[MAG_W-1:0] : nv_reg[MAG_W-1:0];
            magw_in_reg  <= nw_reg[50] ? nw_neg[MAG_W-1:0] : nw_reg[MAG_W-1:0];
            magk_reg     <= magk_next;
            s4_negv_reg  <= nv_reg[50] ^ k_reg[50];
            s4_negw_reg  <= nw_reg[50] ^ k_reg[50];
            s4_degen_reg <= magk_next < DEGEN_LIMIT;
            s4_last_reg  <= s3_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // Weight dividers.
    logic [QUO_W-1:0] qv, qw;
    logic             satv, satw;

    buvm_div u_div_v (
        .clk (clk),
        .en  (adv),
        .num (magv_in_reg),
        .den (magk_reg),
        .quo (qv),
        .sat (satv)
    );

    buvm_div u_div_w (
        .clk (clk),
        .en  (adv),
        .num (magw_in_reg),
        .den (magk_reg),
        .quo (qw),
        .sat (satw)
    );

    // Side flags travel alongside the dividers and the stages after them.
    side_t sb_reg [SB_LEN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SB_LEN; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            sb_reg[0] <= '{v: s4_v_reg, neg_v: s4_negv_reg, neg_w: s4_negw_reg,
                           degen: s4_degen_reg, last: s4_last_reg};
            for (int i = 1; i < SB_LEN; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    // R1: round half away from zero and clamp the magnitudes.
    logic [38:0] rmagv_reg, rmagw_reg;
    logic [40:0] qv_inc, qw_inc;

    assign qv_inc = {1'b0, qv} + 41'd1;
    assign qw_inc = {1'b0, qw} + 41'd1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rmagv_reg <= (satv || qv_inc[40]) ? '1 : qv_inc[39:1];
            rmagw_reg <= (satw || qw_inc[40]) ? '1 : qw_inc[39:1];
        end
    end

    // R2: apply signs.
    logic [39:0] wv_reg, ww_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wv_reg <= sb_reg[DIV_LAT].neg_v ? -{1'b0, rmagv_reg} : {1'b0, rmagv_reg};
            ww_reg <= sb_reg[DIV_LAT].neg_w ? -{1'b0, rmagw_reg} : {1'b0, rmagw_reg};
        end
    end

    // R3: third weight, 1.0 - v - w in Q.24.
    logic [41:0] w_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg[0] <= 42'd16777216 - {{2{wv_reg[39]}}, wv_reg}
                        - {{2{ww_reg[39]}}, ww_reg};
            w_reg[1] <= {{2{wv_reg[39]}}, wv_reg};
            w_reg[2] <= {{2{ww_reg[39]}}, ww_reg};
        end
    end

    // M1: each UV times weight as two 21-bit halves of the weight.
    logic [38:0]        pl_reg [2][3];
    logic signed [39:0] ph_reg [2][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 2; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pl_reg[c][i] <= uv_reg[i][c*UV_W +: UV_W] * w_reg[i][20:0];
                    ph_reg[c][i] <= $signed({1'b0, uv_reg[i][c*UV_W +: UV_W]})
                                    * $signed(w_reg[i][41:21]);
                end
            end
        end
    end

    // M2: recombine halves.
    logic [60:0] prod_reg [2][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 2; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[c][i] <= {ph_reg[c][i], 21'b0} + {22'b0, pl_reg[c][i]};
                end
            end
        end
    end

    // M3: interpolated UV in Q.40.
    logic [60:0] sum_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 2; c++)
            begin
                sum_reg[c] <= prod_reg[c][0] + prod_reg[c][1] + prod_reg[c][2];
            end
        end
    end

    // T1: scale by the texture size in two partial products.
    logic [45:0]        mlo_reg [2];
    logic signed [45:0] mhi_reg [2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 2; c++)
            begin
                mlo_reg[c] <= sum_reg[c][30:0] * size_reg[c];
                mhi_reg[c] <= $signed(sum_reg[c][60:31]) * $signed({1'b0, size_reg[c]});
            end
        end
    end

    // T2: combine and round half up to Q.8.
    logic [44:0] t_reg [2];
    logic [76:0] acc [2];

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            acc[c] = {mhi_reg[c], 31'b0} + {31'b0, mlo_reg[c]} + (77'd1 << 31);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 2; c++)
            begin
                t_reg[c] <= acc[c][76:32];
            end
        end
    end

    // T3: saturate and force zero for a degenerate triangle.
    result_t tail_data_reg;
    logic [TEX_W-1:0] tex_sat [2];
    side_t            t2_side;

    assign t2_side = sb_reg[SB_LEN-1];

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            if (t2_side.degen)
            begin
                tex_sat[c] = '0;
            end
            else if ($signed(t_reg[c]) > 45'sd2147483647)
            begin
                tex_sat[c] = 32'h7FFF_FFFF;
            end
            else if ($signed(t_reg[c]) < -45'sd2147483648)
            begin
                tex_sat[c] = 32'h8000_0000;
            end
            else
            begin
                tex_sat[c] = t_reg[c][TEX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_data_reg.tex_x          <= tex_sat[0];
            tail_data_reg.tex_y          <= tex_sat[1];
            tail_data_reg.degenerate     <= t2_side.degen;
            tail_data_reg.end_of_polygon <= t2_side.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            tail_v_reg <= t2_side.v;
        end
    end

    // Output register with a skid register behind it.
    result_t out_data_reg, skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= push;
            end
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || out_ready)
        begin
            out_data_reg <= skid_v_reg ? skid_data_reg : tail_data_reg;
        end
        else if (push)
        begin
            skid_data_reg <= tail_data_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register holds a beat while the output is empty");

    a_stall_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ready && push) |=> skid_v_reg)
        else $error("beat leaving the pipeline during a stall was not caught");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_data_reg.degenerate) |->
        (out_data_reg.tex_x == '0 && out_data_reg.tex_y == '0))
        else $error("degenerate result carries nonzero coordinates");
`endif

endmodule
